### sv/sli_pkg.sv
// Package with the widths, the stage payload types and the saturation helper for the crossing block.
`timescale 1ns / 1ps
package sli_pkg;
	localparam int CoordBits = 16;
	localparam int FracBits = 16;
	localparam int DiffBits = CoordBits + 1;
	localparam int ProdBits = 2 * DiffBits;
	localparam int CrossBits = ProdBits + 1;
	localparam int MagBits = CrossBits - 1;
	// Offset magnitude never exceeds |u| * 2^FracBits because t lies in [0, 1].
	localparam int QuoBits = DiffBits + FracBits;
	localparam int NumBits = MagBits + DiffBits + FracBits;
	localparam int RemBits = MagBits + 1;
	localparam int SumBits = QuoBits + 2;
	localparam int OutBits = 32;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic signed [DiffBits-1:0] diff_t;
	typedef logic [MagBits-1:0] mag_t;
	typedef logic signed [SumBits-1:0] sum_t;

	function automatic logic signed [OutBits-1:0] sat_out(input sum_t v);
		sum_t hi;
		sum_t lo;
		hi = sum_t'({1'b0, {(OutBits-1){1'b1}}});
		lo = -hi - sum_t'(1);
		if (v > hi) begin
			sat_out = hi[OutBits-1:0];
		end else if (v < lo) begin
			sat_out = lo[OutBits-1:0];
		end else begin
			sat_out = v[OutBits-1:0];
		end
	endfunction
endpackage

### sv/sli_div.sv
// Pipelined restoring divider: one quotient bit per stage, two offsets side by side.
`timescale 1ns / 1ps
module sli_div (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [sli_pkg::NumBits-1:0] num_x,
	input  logic [sli_pkg::NumBits-1:0] num_y,
	input  sli_pkg::mag_t den,
	input  logic neg_x,
	input  logic neg_y,
	input  logic [sli_pkg::CoordBits-1:0] ax,
	input  logic [sli_pkg::CoordBits-1:0] ay,
	input  logic on_seg,
	input  logic par,
	output logic out_valid,
	output logic [sli_pkg::QuoBits-1:0] quo_x,
	output logic [sli_pkg::QuoBits-1:0] quo_y,
	output logic round_x,
	output logic round_y,
	output logic out_neg_x,
	output logic out_neg_y,
	output logic [sli_pkg::CoordBits-1:0] out_ax,
	output logic [sli_pkg::CoordBits-1:0] out_ay,
	output logic out_on,
	output logic out_par
);
	localparam int N = sli_pkg::QuoBits;
	localparam int R = sli_pkg::RemBits;

	typedef struct packed {
		logic on_seg;
		logic par;
		logic neg_x;
		logic neg_y;
		logic [sli_pkg::CoordBits-1:0] ax;
		logic [sli_pkg::CoordBits-1:0] ay;
		sli_pkg::mag_t den;
	} side_t;

	logic vld_s [1:N];
	side_t side_s [1:N];
	logic [R-1:0] rx_s [1:N];
	logic [R-1:0] ry_s [1:N];
	logic [N-1:0] nx_s [1:N];
	logic [N-1:0] ny_s [1:N];
	logic [N-1:0] qx_s [1:N];
	logic [N-1:0] qy_s [1:N];

	for (genvar i = 0; i < N; i++) begin : g_st
		logic v_in;
		side_t s_in;
		logic [R-1:0] rx_in;
		logic [R-1:0] ry_in;
		logic [N-1:0] nx_in;
		logic [N-1:0] ny_in;
		logic [N-1:0] qx_in;
		logic [N-1:0] qy_in;
		logic [R-1:0] tx;
		logic [R-1:0] ty;
		logic [R-1:0] dn;
		logic bit_x;
		logic bit_y;
		if (i == 0) begin : g_first
			// The high bits of the dividend lie below the divisor and seed the remainder.
			always_comb begin
				v_in = in_valid;
				s_in = '{on_seg, par, neg_x, neg_y, ax, ay, den};
				rx_in = R'(num_x[sli_pkg::NumBits-1:N]);
				ry_in = R'(num_y[sli_pkg::NumBits-1:N]);
				nx_in = num_x[N-1:0];
				ny_in = num_y[N-1:0];
				qx_in = '0;
				qy_in = '0;
			end
		end else begin : g_next
			always_comb begin
				v_in = vld_s[i];
				s_in = side_s[i];
				rx_in = rx_s[i];
				ry_in = ry_s[i];
				nx_in = nx_s[i];
				ny_in = ny_s[i];
				qx_in = qx_s[i];
				qy_in = qy_s[i];
			end
		end
		always_comb begin
			dn = R'(s_in.den);
			tx = {rx_in[R-2:0], nx_in[N-1-i]};
			ty = {ry_in[R-2:0], ny_in[N-1-i]};
			bit_x = (tx >= dn);
			bit_y = (ty >= dn);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			side_s[i+1] <= s_in;
			rx_s[i+1] <= bit_x ? tx - dn : tx;
			ry_s[i+1] <= bit_y ? ty - dn : ty;
			nx_s[i+1] <= nx_in;
			ny_s[i+1] <= ny_in;
			qx_s[i+1] <= {qx_in[N-2:0], bit_x};
			qy_s[i+1] <= {qy_in[N-2:0], bit_y};
		end
	end

	logic [R:0] rx2;
	logic [R:0] ry2;
	always_comb begin
		rx2 = {rx_s[N], 1'b0};
		ry2 = {ry_s[N], 1'b0};
		out_valid = vld_s[N];
		quo_x = qx_s[N];
		quo_y = qy_s[N];
		// Ties round away from zero: bump when twice the remainder reaches the divisor.
		round_x = rx2 >= (R+1)'(side_s[N].den);
		round_y = ry2 >= (R+1)'(side_s[N].den);
		out_neg_x = side_s[N].neg_x;
		out_neg_y = side_s[N].neg_y;
		out_ax = side_s[N].ax;
		out_ay = side_s[N].ay;
		out_on = side_s[N].on_seg;
		out_par = side_s[N].par;
	end
endmodule

### sv/segment_line_intersection.sv
// Top level: crossing point of two lines with a range test on the first segment.
//  channel | handshake        | words
//  in      | start, busy      | eight endpoint coordinates
//  out     | done (strobe)    | on_first_segment, lines_parallel, cross_x, cross_y
// One word enters each cycle; busy stays low. Between the accepting edge and done lie the
// registers for differences, products, cross products with sign fold, dividend products,
// then one divider stage per quotient bit, then rounding and saturation.
// Reset clears only the valid bits.
// The receiver cannot stall, so nothing ever backs up in the pipeline.
`timescale 1ns / 1ps
module segment_line_intersection (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sli_pkg::coord_t first_start_x,
	input  sli_pkg::coord_t first_start_y,
	input  sli_pkg::coord_t first_end_x,
	input  sli_pkg::coord_t first_end_y,
	input  sli_pkg::coord_t second_start_x,
	input  sli_pkg::coord_t second_start_y,
	input  sli_pkg::coord_t second_end_x,
	input  sli_pkg::coord_t second_end_y,
	output logic done,
	output logic on_first_segment,
	output logic lines_parallel,
	output logic signed [31:0] cross_x,
	output logic signed [31:0] cross_y
);
	localparam int D = sli_pkg::DiffBits;
	localparam int P = sli_pkg::ProdBits;
	localparam int C = sli_pkg::CrossBits;
	localparam int M = sli_pkg::MagBits;
	localparam int F = sli_pkg::FracBits;
	localparam int NB = sli_pkg::NumBits;

	assign busy = 1'b0;

	// Stage 1: differences.
	logic v_s1;
	sli_pkg::diff_t ux_s1, uy_s1, vx_s1, vy_s1, wx_s1, wy_s1;
	sli_pkg::coord_t ax_s1, ay_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end
	always_ff @(posedge clk) begin
		ux_s1 <= D'(first_end_x) - D'(first_start_x);
		uy_s1 <= D'(first_end_y) - D'(first_start_y);
		vx_s1 <= D'(second_end_x) - D'(second_start_x);
		vy_s1 <= D'(second_end_y) - D'(second_start_y);
		wx_s1 <= D'(second_start_x) - D'(first_start_x);
		wy_s1 <= D'(second_start_y) - D'(first_start_y);
		ax_s1 <= first_start_x;
		ay_s1 <= first_start_y;
	end

	// Stage 2: the four products.
	logic v_s2;
	logic signed [P-1:0] p0_s2, p1_s2, p2_s2, p3_s2;
	sli_pkg::diff_t ux_s2, uy_s2;
	sli_pkg::coord_t ax_s2, ay_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		p0_s2 <= P'(ux_s1) * P'(vy_s1);
		p1_s2 <= P'(uy_s1) * P'(vx_s1);
		p2_s2 <= P'(wx_s1) * P'(vy_s1);
		p3_s2 <= P'(wy_s1) * P'(vx_s1);
		ux_s2 <= ux_s1;
		uy_s2 <= uy_s1;
		ax_s2 <= ax_s1;
		ay_s2 <= ay_s1;
	end

	// Stage 3: cross products, sign fold onto a positive denominator, range test.
	logic signed [C-1:0] den_c, tn_c, den_f, tn_f;
	always_comb begin
		den_c = C'(p0_s2) - C'(p1_s2);
		tn_c = C'(p2_s2) - C'(p3_s2);
		den_f = den_c[C-1] ? -den_c : den_c;
		tn_f = den_c[C-1] ? -tn_c : tn_c;
	end
	logic v_s3, par_s3, on_s3;
	logic [M-1:0] den_s3, tn_s3;
	sli_pkg::diff_t ux_s3, uy_s3;
	sli_pkg::coord_t ax_s3, ay_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		par_s3 <= (den_c == '0);
		on_s3 <= (den_c != '0) && !tn_f[C-1] && (tn_f <= den_f);
		den_s3 <= den_f[M-1:0];
		tn_s3 <= tn_f[M-1:0];
		ux_s3 <= ux_s2;
		uy_s3 <= uy_s2;
		ax_s3 <= ax_s2;
		ay_s3 <= ay_s2;
	end

	// Stage 4: dividend magnitudes |u| * tn * 2^F.
	logic v_s4, par_s4, on_s4, nx_s4, ny_s4;
	logic [NB-1:0] numx_s4, numy_s4;
	logic [M-1:0] den_s4;
	sli_pkg::coord_t ax_s4, ay_s4;
	logic [D-1:0] mux, muy;
	always_comb begin
		mux = ux_s3[D-1] ? D'(-ux_s3) : D'(ux_s3);
		muy = uy_s3[D-1] ? D'(-uy_s3) : D'(uy_s3);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		// A failed test yields zero offsets, so a dummy nonzero divisor keeps things defined.
		numx_s4 <= on_s3 ? {(NB-F)'(mux) * (NB-F)'(tn_s3), {F{1'b0}}} : '0;
		numy_s4 <= on_s3 ? {(NB-F)'(muy) * (NB-F)'(tn_s3), {F{1'b0}}} : '0;
		den_s4 <= on_s3 ? den_s3 : M'(1);
		nx_s4 <= ux_s3[D-1];
		ny_s4 <= uy_s3[D-1];
		par_s4 <= par_s3;
		on_s4 <= on_s3;
		ax_s4 <= ax_s3;
		ay_s4 <= ay_s3;
	end

	logic dv, rx, ry, dnx, dny, don, dpar;
	logic [sli_pkg::QuoBits-1:0] qx, qy;
	logic [sli_pkg::CoordBits-1:0] dax, day;
	sli_div u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s4),
		.num_x(numx_s4), .num_y(numy_s4), .den(den_s4),
		.neg_x(nx_s4), .neg_y(ny_s4), .ax(ax_s4), .ay(ay_s4),
		.on_seg(on_s4), .par(par_s4),
		.out_valid(dv), .quo_x(qx), .quo_y(qy), .round_x(rx), .round_y(ry),
		.out_neg_x(dnx), .out_neg_y(dny), .out_ax(dax), .out_ay(day),
		.out_on(don), .out_par(dpar)
	);

	// Final stage: round, sign, add A in the output format, saturate.
	sli_pkg::sum_t ox, oy, bx, by;
	always_comb begin
		ox = sli_pkg::sum_t'(qx) + sli_pkg::sum_t'(rx);
		oy = sli_pkg::sum_t'(qy) + sli_pkg::sum_t'(ry);
		if (dnx) ox = -ox;
		if (dny) oy = -oy;
		bx = sli_pkg::sum_t'($signed(dax)) <<< F;
		by = sli_pkg::sum_t'($signed(day)) <<< F;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv;
		end
	end
	always_ff @(posedge clk) begin
		on_first_segment <= don;
		lines_parallel <= dpar;
		cross_x <= sli_pkg::sat_out(don ? bx + ox : bx);
		cross_y <= sli_pkg::sat_out(don ? by + oy : by);
	end

`ifndef SYNTHESIS
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(on_first_segment && lines_parallel))
		else $error("crossing flagged both on segment and parallel");
	a_fold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !par_s3 |-> den_s3 != '0)
		else $error("nonparallel item with zero divisor");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> ##(sli_pkg::QuoBits + 1) done)
		else $error("word lost in divider pipeline");
`endif
endmodule

### tb/sv/segment_line_intersection_tb.sv
// Testbench for the segment and line crossing block: directed cases, random pairs, self-checking.
`timescale 1ns / 1ps
module segment_line_intersection_tb;
	typedef sli_pkg::coord_t pair_t [8];
	typedef struct {
		logic on_seg;
		logic par;
		logic signed [31:0] px;
		logic signed [31:0] py;
	} crossing_t;

	localparam int WatchLimit = 4000;
	localparam int DrainCycles = sli_pkg::QuoBits + 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	sli_pkg::coord_t first_start_x = '0, first_start_y = '0;
	sli_pkg::coord_t first_end_x = '0, first_end_y = '0;
	sli_pkg::coord_t second_start_x = '0, second_start_y = '0;
	sli_pkg::coord_t second_end_x = '0, second_end_y = '0;
	logic done;
	logic on_first_segment;
	logic lines_parallel;
	logic signed [31:0] cross_x;
	logic signed [31:0] cross_y;

	crossing_t pending_crossings [$];
	int mismatches = 0;
	int idle_pct = 0;
	int quiet_cycles = 0;

	segment_line_intersection dut (.*);

	always #6 clk = ~clk;

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Offset along one axis: round(dv * tn * 2^FracBits / den), ties away from zero.
	function automatic longint rounded_offset(input longint dv, input longint tn,
			input longint den);
		logic [127:0] num;
		logic [127:0] q;
		logic [127:0] r;
		logic [127:0] d;
		logic [63:0] mag;
		mag = (dv < 0) ? -dv : dv;
		d = {64'b0, den};
		num = ({64'b0, mag} * {64'b0, tn}) << sli_pkg::FracBits;
		q = num / d;
		r = num % d;
		if (r >= d - r) q = q + 1;
		return (dv < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic crossing_t predict_crossing(input pair_t p);
		crossing_t c;
		longint ax, ay, ux, uy, vx, vy, wx, wy, den, tn;
		ax = p[0];
		ay = p[1];
		ux = longint'(p[2]) - ax;
		uy = longint'(p[3]) - ay;
		vx = longint'(p[6]) - longint'(p[4]);
		vy = longint'(p[7]) - longint'(p[5]);
		wx = longint'(p[4]) - ax;
		wy = longint'(p[5]) - ay;
		den = ux * vy - uy * vx;
		tn = wx * vy - wy * vx;
		c.on_seg = 1'b0;
		c.par = 1'b0;
		c.px = clamp32(ax <<< sli_pkg::FracBits);
		c.py = clamp32(ay <<< sli_pkg::FracBits);
		if (den == 0) begin
			c.par = 1'b1;
		end else begin
			if (den < 0) begin
				den = -den;
				tn = -tn;
			end
			if (tn >= 0 && tn <= den) begin
				c.on_seg = 1'b1;
				c.px = clamp32((ax <<< sli_pkg::FracBits) + rounded_offset(ux, tn, den));
				c.py = clamp32((ay <<< sli_pkg::FracBits) + rounded_offset(uy, tn, den));
			end
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Drives one word and holds it until the block takes it.
	task automatic send_pair(input pair_t p);
		logic was_busy;
		first_start_x <= p[0];
		first_start_y <= p[1];
		first_end_x <= p[2];
		first_end_y <= p[3];
		second_start_x <= p[4];
		second_start_y <= p[5];
		second_end_x <= p[6];
		second_end_y <= p[7];
		start <= 1'b1;
		do begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
		end while (was_busy);
		pending_crossings.push_back(predict_crossing(p));
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic hold_until_drained();
		start <= 1'b0;
		while (pending_crossings.size() != 0) @(posedge clk);
	endtask

	function automatic sli_pkg::coord_t rand_coord(input int span);
		if (span == 0) return sli_pkg::coord_t'($urandom);
		return sli_pkg::coord_t'($urandom_range(2 * span) - span);
	endfunction

	task automatic test_directed();
		pair_t p;
		sli_pkg::coord_t mn, mx;
		mn = 16'sh8000;
		mx = 16'sh7fff;
		p = '{mn, mn, mx, mx, mn, mx, mx, mn}; send_pair(p);
		p = '{mx, mx, mn, mn, mx, mn, mn, mx}; send_pair(p);
		p = '{mn, mx, mx, mn, mn, mn, mx, mx}; send_pair(p);
		p = '{mx, mn, mn, mx, mn, mn, mx, mx}; send_pair(p);
		p = '{mn, mn, mx, mn, mn, mx, mx, mx}; send_pair(p);	// parallel horizontals
		p = '{0, -5, 0, 5, -3, 1, 3, 1}; send_pair(p);		// vertical first segment
		p = '{-5, 2, 5, 2, 1, -4, 1, 4}; send_pair(p);		// vertical second segment
		p = '{0, 0, 4, 4, 1, 1, 3, 3}; send_pair(p);			// collinear overlap
		p = '{3, 3, 3, 3, 0, 0, 1, 5}; send_pair(p);			// zero-length first
		p = '{0, 0, 4, 1, 2, 2, 2, 2}; send_pair(p);			// zero-length second
		p = '{0, 0, 4, 0, 0, -1, 0, 1}; send_pair(p);		// crossing at the start
		p = '{0, 0, 4, 0, 4, -1, 4, 1}; send_pair(p);		// crossing at the end
		p = '{0, 0, 4, 0, 5, -1, 5, 1}; send_pair(p);		// just past the end
		p = '{0, 0, 4, 0, -1, -1, -1, 1}; send_pair(p);		// just before the start
		p = '{0, 0, 3, 1, 1, -7, 2, 9}; send_pair(p);		// rounding of a fraction
		p = '{0, 0, -3, -1, -1, 7, -2, -9}; send_pair(p);	// negative offsets
		p = '{0, 0, 2, 0, 1, 0, 2, 1}; send_pair(p);			// half-way point
		p = '{mx, mx, mn, mn, 0, 5, 5, 0}; send_pair(p);
		p = '{mn, 0, mx, 0, 0, mn, 1, mx}; send_pair(p);
		p = '{0, mn, 0, mx, mn, 7, mx, 7}; send_pair(p);
	endtask

	task automatic test_random(input int count, input int sender_idle);
		pair_t p;
		int kind, k;
		idle_pct = sender_idle;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(99);
			if (kind < 30) begin
				foreach (p[i]) p[i] = rand_coord(0);
			end else if (kind < 75) begin
				foreach (p[i]) p[i] = rand_coord((kind < 55) ? 10 : 3000);
			end else if (kind < 90) begin
				// Second segment parallel to the first, or of zero length.
				foreach (p[i]) p[i] = rand_coord(200);
				k = $urandom_range(3) - 1;
				p[6] = p[4] + k * (p[2] - p[0]);
				p[7] = p[5] + k * (p[3] - p[1]);
			end else begin
				// Second segment passes through a point of the first.
				foreach (p[i]) p[i] = rand_coord(1000);
				k = $urandom_range(8);
				p[6] = 2 * (p[0] + k * (p[2] - p[0]) / 8) - p[4];
				p[7] = 2 * (p[1] + k * (p[3] - p[1]) / 8) - p[5];
			end
			send_pair(p);
			if (n == count / 2 && sender_idle == 72) hold_until_drained();
		end
	endtask

	always @(negedge clk) begin
		crossing_t want;
		if (arst_n && done) begin
			if (pending_crossings.size() == 0) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				want = pending_crossings.pop_front();
				if (on_first_segment !== want.on_seg)
					report_mismatch("on_first_segment", on_first_segment, want.on_seg);
				if (lines_parallel !== want.par)
					report_mismatch("lines_parallel", lines_parallel, want.par);
				if (cross_x !== want.px) report_mismatch("cross_x", cross_x, want.px);
				if (cross_y !== want.py) report_mismatch("cross_y", cross_y, want.py);
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WatchLimit) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(250, 33);
		test_random(250, 72);
		test_random(250, 0);
		start <= 1'b0;
		while (pending_crossings.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
